// File: hw/rtl/erle_pkg.sv
// Shared types for the zero-escape run-length byte decoder.
`default_nettype none

package erle_pkg;

  localparam int CNT_W = 24;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_TRUNC    = 2'd2
  } status_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t            op;
    logic [CNT_W-1:0]   a;
    logic [CNT_W-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic [CNT_W-1:0]   res;
    logic               borrow;
    logic               zero;
  } alu_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/erle_if.sv
// Request channel interfaces for compressed input bytes and packed result words.
`default_nettype none

interface erle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface erle_out_if
  import erle_pkg::*;
#(
  parameter int BYTES_PER_WORD = 4
);
  localparam int WW = 8 * BYTES_PER_WORD;
  localparam int CW = $clog2(BYTES_PER_WORD + 1);

  logic          valid;
  logic          ready;
  logic [WW-1:0] out_word;
  logic [CW-1:0] out_count;
  logic          item_last;
  logic          stream_end;
  status_t       status;

  modport source (output valid, output out_word, output out_count, output item_last,
                  output stream_end, output status, input ready);
  modport sink   (input valid, input out_word, input out_count, input item_last,
                  input stream_end, input status, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/erle_alu.sv
// Shared add/subtract-compare unit used by the decoder sequencer.
`default_nettype none

module erle_alu
  import erle_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic             sub;
  logic [CNT_W-1:0] b_in;
  logic [CNT_W:0]   sum;

  assign sub  = (req.op == ALU_SUB);
  assign b_in = sub ? ~req.b : req.b;
  assign sum  = {1'b0, req.a} + {1'b0, b_in} + {{CNT_W{1'b0}}, sub};

  assign rsp.res    = sum[CNT_W-1:0];
  assign rsp.borrow = sub & ~sum[CNT_W];
  assign rsp.zero   = (sum[CNT_W-1:0] == '0);

endmodule

`default_nettype wire

// File: hw/rtl/escape_rle_byte_decoder.sv
// Top level: zero-escape run-length byte decoder with packed output words.
// Escape and value bytes go straight to the empty step, which loads the result
// register. Literals and runs pass room, clamp, count update and emit steps, then
// one word per cycle while the output is free, ceil(kept/BYTES_PER_WORD) words.
// Input is taken only between items; one shared add/compare unit sets the pace.
// Synchronous reset clears parse state and the written count; limit resets to max.
`default_nettype none

module escape_rle_byte_decoder
  import erle_pkg::*;
#(
  parameter int BYTES_PER_WORD = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [23:0] cfg_wdata,
  erle_in_if.sink          din,
  erle_out_if.source       dout
);

  localparam int WW = 8 * BYTES_PER_WORD;
  localparam int CW = $clog2(BYTES_PER_WORD + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_ROOM, S_KEPT, S_ADD, S_EMIT, S_EMPTY
  } state_t;

  typedef enum logic [1:0] {
    PH_LIT   = 2'd0,
    PH_VALUE = 2'd1,
    PH_COUNT = 2'd2
  } phase_t;

  state_t           state;
  phase_t           phase;
  logic [7:0]       held;
  logic [CNT_W-1:0] written;
  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] room;
  logic             ovf;
  logic [7:0]       run_val;
  logic [7:0]       run_cnt;
  logic [7:0]       rem;
  logic             lst;
  logic             trunc;

  logic             o_valid;
  logic [WW-1:0]    o_word;
  logic [CW-1:0]    o_count;
  logic             o_item_last;
  logic             o_stream_end;
  status_t          o_status;

  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;
  logic             out_free;
  logic             o_load;
  logic [CW-1:0]    cnt_emit;
  logic [7:0]       rem_emit;
  logic [WW-1:0]    word_fill;

  erle_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign out_free = !o_valid || dout.ready;
  assign o_load   = out_free && ((state == S_EMIT) || (state == S_EMPTY));

  always_comb begin
    alu_req.op = ALU_SUB;
    alu_req.a  = '0;
    alu_req.b  = '0;
    unique case (state)
      S_ROOM: begin
        alu_req.a = limit;
        alu_req.b = written;
      end
      S_KEPT: begin
        alu_req.a = {{(CNT_W-8){1'b0}}, run_cnt};
        alu_req.b = room;
      end
      S_ADD: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = written;
        alu_req.b  = {{(CNT_W-8){1'b0}}, rem};
      end
      S_EMIT: begin
        alu_req.a = {{(CNT_W-8){1'b0}}, rem};
        alu_req.b = CNT_W'(BYTES_PER_WORD);
      end
      default: ;
    endcase
  end

  // one word step: a short tail takes what is left
  assign cnt_emit = alu_rsp.borrow ? rem[CW-1:0] : CW'(BYTES_PER_WORD);
  assign rem_emit = alu_rsp.borrow ? 8'h00 : alu_rsp.res[7:0];

  always_comb begin
    for (int i = 0; i < BYTES_PER_WORD; i++) begin
      word_fill[8*i +: 8] = (CW'(i) < cnt_emit) ? run_val : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      phase   <= PH_LIT;
      held    <= '0;
      written <= '0;
      limit   <= '1;
      ovf     <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_wdata;
      end
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (dout.ready) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (din.valid) begin
            lst <= din.in_last;
            unique case (phase)
              PH_VALUE: begin
                held  <= din.in_byte;
                phase <= PH_COUNT;
                trunc <= din.in_last;
                state <= S_EMPTY;
              end
              PH_COUNT: begin
                phase   <= PH_LIT;
                trunc   <= 1'b0;
                run_val <= held;
                run_cnt <= din.in_byte;
                state   <= S_ROOM;
              end
              default: begin
                if (din.in_byte == 8'h00) begin
                  phase <= PH_VALUE;
                  trunc <= din.in_last;
                  state <= S_EMPTY;
                end else begin
                  phase   <= PH_LIT;
                  trunc   <= 1'b0;
                  run_val <= din.in_byte;
                  run_cnt <= 8'd1;
                  state   <= S_ROOM;
                end
              end
            endcase
          end
        end
        S_ROOM: begin
          room  <= alu_rsp.borrow ? '0 : alu_rsp.res;
          state <= S_KEPT;
        end
        S_KEPT: begin
          if (alu_rsp.borrow) begin
            rem <= run_cnt;
          end else begin
            rem <= room[7:0];
            if (!alu_rsp.zero) begin
              ovf <= 1'b1;
            end
          end
          state <= S_ADD;
        end
        S_ADD: begin
          written <= alu_rsp.res;
          state   <= (rem == 8'h00) ? S_EMPTY : S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            o_word       <= word_fill;
            o_count      <= cnt_emit;
            o_item_last  <= (rem_emit == 8'h00);
            o_stream_end <= lst && (rem_emit == 8'h00);
            o_status     <= ovf ? ST_OVERFLOW : ST_OK;
            rem          <= rem_emit;
            if (rem_emit == 8'h00) begin
              state <= S_IDLE;
              if (lst) begin
                phase   <= PH_LIT;
                held    <= '0;
                written <= '0;
                ovf     <= 1'b0;
              end
            end
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            o_word       <= '0;
            o_count      <= '0;
            o_item_last  <= 1'b1;
            o_stream_end <= lst;
            o_status     <= trunc ? ST_TRUNC : (ovf ? ST_OVERFLOW : ST_OK);
            state        <= S_IDLE;
            if (lst) begin
              phase   <= PH_LIT;
              held    <= '0;
              written <= '0;
              ovf     <= 1'b0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign din.ready       = (state == S_IDLE);
  assign dout.valid      = o_valid;
  assign dout.out_word   = o_word;
  assign dout.out_count  = o_count;
  assign dout.item_last  = o_item_last;
  assign dout.stream_end = o_stream_end;
  assign dout.status     = o_status;

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    din.valid && din.ready |=> !din.ready)
    else $error("input taken again before item finished");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    dout.valid |-> (dout.out_count <= CW'(BYTES_PER_WORD)))
    else $error("result byte count exceeds word size");

  a_trunc_last: assert property (@(posedge clk) disable iff (rst)
    dout.valid && (dout.status == ST_TRUNC) |-> dout.item_last && dout.stream_end)
    else $error("truncation flagged on a non-final result");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.stream_end |-> dout.item_last)
    else $error("stream end without item end");

endmodule

`default_nettype wire

// File: tb/sv/escape_rle_byte_decoder_tb.sv
// Self-checking testbench for the zero-escape run-length byte decoder.
`default_nettype none

module escape_rle_byte_decoder_tb
  import erle_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BPW         = 4;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_GAP   = 16;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [8*BPW-1:0] word;
    logic [2:0]       count;
    logic             item_last;
    logic             stream_end;
    status_t          status;
  } dec_word_t;

  class run_expander;
    logic [23:0] limit;
    logic [1:0]  phase;
    logic [7:0]  held;
    logic [23:0] written;
    bit          over;
    dec_word_t   pending_words[$];
    int          mismatches;

    function new();
      limit      = 24'hFFFFFF;
      mismatches = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      phase   = 2'd0;
      held    = 8'd0;
      written = 24'd0;
      over    = 1'b0;
    endfunction

    function void set_limit(logic [23:0] v);
      limit = v;
    endfunction

    // expand one accepted request into its result words
    function void take_byte(logic [7:0] b, logic l);
      dec_word_t batch[$];
      dec_word_t w;
      dec_word_t blank;
      int        room;
      int        kept;
      bit        trunc;
      blank = '0;
      trunc = 1'b0;
      room  = (written >= limit) ? 0 : int'(limit - written);
      case (phase)
        2'd1: begin
          held  = b;
          phase = 2'd2;
          trunc = l;
          batch = {batch, blank};
        end
        2'd2: begin
          kept  = (int'(b) < room) ? int'(b) : room;
          phase = 2'd0;
          if (int'(b) > kept) over = 1'b1;
          written = written + 24'(kept);
          for (int i = 0; i < kept; i += BPW) begin
            w = '0;
            for (int c = 0; c < BPW && i + c < kept; c++) begin
              w.word[8*c +: 8] = held;
              w.count          = 3'(c + 1);
            end
            batch = {batch, w};
          end
          if (batch.size() == 0) batch = {batch, blank};
        end
        default: begin
          phase = 2'd0;
          if (b == 8'd0) begin
            phase = 2'd1;
            trunc = l;
            batch = {batch, blank};
          end else if (room > 0) begin
            written      = written + 24'd1;
            w            = '0;
            w.word[7:0]  = b;
            w.count      = 3'd1;
            batch = {batch, w};
          end else begin
            over = 1'b1;
            batch = {batch, blank};
          end
        end
      endcase
      foreach (batch[k]) batch[k].status = over ? ST_OVERFLOW : ST_OK;
      batch[batch.size()-1].item_last  = 1'b1;
      batch[batch.size()-1].stream_end = l;
      if (trunc) batch[batch.size()-1].status = ST_TRUNC;
      pending_words = {pending_words, batch};
      if (l) clear_stream();
    endfunction

    function void match_word(dec_word_t got);
      dec_word_t want;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word=%h count=%0d item_last=%b stream_end=%b status=%0d",
                   got.word, got.count, got.item_last, got.stream_end, got.status);
        return;
      end
      want = pending_words.pop_front();
      if (got.word !== want.word || got.count !== want.count ||
          got.item_last !== want.item_last || got.stream_end !== want.stream_end ||
          got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected word=%h count=%0d item_last=%b stream_end=%b st=%0d",
                   want.word, want.count, want.item_last, want.stream_end, want.status);
          $display("          got      word=%h count=%0d item_last=%b stream_end=%b st=%0d",
                   got.word, got.count, got.item_last, got.stream_end, got.status);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [23:0] cfg_wdata;

  erle_in_if                         req_ch ();
  erle_out_if #(.BYTES_PER_WORD(BPW)) rsp_ch ();

  escape_rle_byte_decoder #(.BYTES_PER_WORD(BPW)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .din       (req_ch),
    .dout      (rsp_ch)
  );

  run_expander expander = new();

  bit tx_jitter;
  bit rx_jitter;
  bit hold_request;
  int rx_hold_left;
  int sent_items;
  int cycles;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      rx_hold_left--;
    end else if (hold_request) begin
      hold_request = 1'b0;
      rx_hold_left = HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= !(rx_jitter && $urandom_range(99) < 35);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      expander.match_word(dec_word_t'{rsp_ch.out_word, rsp_ch.out_count, rsp_ch.item_last,
                                      rsp_ch.stream_end, rsp_ch.status});
  end

  task automatic push_byte(input logic [7:0] b, input logic l);
    while (tx_jitter && $urandom_range(99) < 35) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.in_byte <= b;
    req_ch.in_last <= l;
    do @(posedge clk); while (!req_ch.ready);
    expander.take_byte(b, l);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic push_run(input logic [7:0] v, input logic [7:0] n, input logic l);
    push_byte(8'd0, 1'b0);
    push_byte(v, 1'b0);
    push_byte(n, l);
  endtask

  task automatic drain_and_wait();
    req_ch.valid <= 1'b0;
    while (expander.pending_words.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  task automatic set_limit(input logic [23:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    expander.set_limit(v);
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_run_length();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 8'($urandom_range(0, 12));
    if (r < 90) return 8'($urandom_range(13, 64));
    return 8'($urandom_range(65, 255));
  endfunction

  task automatic random_token();
    int   r;
    logic l;
    r = $urandom_range(99);
    l = ($urandom_range(9) == 0);
    if (r < 45) begin
      push_byte(8'($urandom_range(1, 255)), l);
    end else if (r < 88) begin
      push_run(8'($urandom_range(0, 255)), pick_run_length(), l);
    end else if (r < 94) begin
      push_byte(8'd0, 1'b1);
    end else begin
      push_byte(8'd0, 1'b0);
      push_byte(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  initial begin
    int phase_start;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    req_ch.valid   = 1'b0;
    req_ch.in_byte = '0;
    req_ch.in_last = 1'b0;
    rsp_ch.ready   = 1'b0;
    tx_jitter      = 1'b1;
    rx_jitter      = 1'b1;
    hold_request   = 1'b0;
    rx_hold_left   = 0;
    sent_items     = 0;
    cycles         = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: literals, full and empty runs, truncation, overflow, lowered limit
    set_limit(24'hFFFFFF);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h01, 1'b0);
    push_run(8'hAA, 8'd255, 1'b0);
    push_run(8'h00, 8'd0, 1'b0);
    push_run(8'h7F, 8'd6, 1'b1);
    push_byte(8'd0, 1'b1);
    push_byte(8'd0, 1'b0);
    push_byte(8'h80, 1'b1);
    drain_and_wait();
    set_limit(24'd3);
    push_byte(8'h22, 1'b0);
    push_run(8'h99, 8'd5, 1'b0);
    push_byte(8'h44, 1'b1);
    drain_and_wait();
    set_limit(24'd8);
    for (int i = 1; i <= 4; i++) push_byte(8'(i), 1'b0);
    drain_and_wait();
    set_limit(24'd2);
    push_run(8'h66, 8'd2, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      drain_and_wait();
      tx_jitter = (ph != 0);
      rx_jitter = (ph != 0);
      case (ph)
        0, 1:    set_limit(24'hFFFFFF);
        3:       set_limit(24'd0);
        4:       set_limit(24'($urandom_range(0, 24'hFFFFFF)));
        default: set_limit(24'($urandom_range(1, 48)));
      endcase
      phase_start = sent_items;
      if (ph == 1) begin
        hold_request = 1'b1;
        push_run(8'hC3, 8'd200, 1'b0);
      end
      while (sent_items < phase_start + 16) random_token();
    end
    drain_and_wait();

    if (expander.mismatches == 0 && expander.pending_words.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
